// ----- hdl/nqcs_pkg.sv -----
// Package for the Newton-Raphson current solver: widths, beat structs and
// per-stage work record. No dependencies.
`default_nettype none

package nqcs_pkg;

  localparam int unsigned NewtonSteps = 10;

  localparam int unsigned XW = 16;        // Q8.8 current / intensity
  localparam int unsigned QW = 17;        // quotient bits kept (saturating)
  localparam int unsigned DW = 34;        // derivative width, 20 frac bits
  localparam int unsigned PW = 49;        // f magnitude width, 28 frac bits
  localparam int unsigned RW = PW + 1;    // dividend incl. rounding term

  localparam logic [XW-1:0] XMax = '1;

  typedef struct packed {
    logic [15:0] intensity;
    logic [15:0] coef_a;
    logic [15:0] coef_b;
  } nqcs_in_t;

  typedef struct packed {
    logic [15:0] drive_current;
    logic        solve_error;
  } nqcs_out_t;

  // state of one item between Newton steps
  typedef struct packed {
    logic [XW-1:0] x;
    logic [15:0]   a;
    logic [15:0]   b;
    logic [15:0]   c;
    logic          err;
  } nqcs_item_t;

  // working record inside one step
  typedef struct packed {
    nqcs_item_t    item;
    logic [31:0]   ax;
    logic [31:0]   bx;
    logic [47:0]   axx;
    logic [DW-1:0] d;
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
    logic          fneg;
    logic          dz;
    logic          over;
  } nqcs_work_t;

endpackage

`default_nettype wire

// ----- hdl/nqcs_step.sv -----
// One Newton-Raphson step as a pipeline: products, f and f', then one
// quotient bit per stage, then the update with saturation. Uses nqcs_pkg.
`default_nettype none

module nqcs_step (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire nqcs_pkg::nqcs_item_t item_i,
  output logic                     valid_o,
  output nqcs_pkg::nqcs_item_t     item_o
);
  import nqcs_pkg::*;

  localparam int unsigned NumWork = 3 + QW;

  nqcs_work_t          work_d [NumWork];
  nqcs_work_t          work_q [NumWork];
  logic [NumWork-1:0]  vld_q;
  nqcs_item_t          item_d;
  nqcs_item_t          item_q;
  logic                item_vld_q;

  always_comb begin
    logic [48:0]   pos;
    logic [48:0]   negv;
    logic [48:0]   mag;
    logic [RW-1:0] num;
    logic [RW-1:0] dsh;
    logic [QW-1:0] qv;
    logic [XW+1:0] sum;
    nqcs_work_t    src;

    // stage A: a*x and b*x
    work_d[0]      = '0;
    work_d[0].item = item_i;
    work_d[0].ax   = item_i.a * item_i.x;
    work_d[0].bx   = item_i.b * item_i.x;

    // stage B: a*x*x and the derivative
    work_d[1]     = work_q[0];
    work_d[1].axx = work_q[0].ax * work_q[0].item.x;
    work_d[1].d   = {1'b0, work_q[0].ax, 1'b0} + {10'b0, work_q[0].item.b, 8'b0};

    // stage C: signed f as sign and magnitude, rounding term, range check
    src  = work_q[1];
    pos  = {1'b0, src.axx} + {9'b0, src.bx, 8'b0};
    negv = {13'b0, src.item.c, 20'b0};
    work_d[2]      = src;
    work_d[2].fneg = (pos < negv);
    mag  = work_d[2].fneg ? (negv - pos) : (pos - negv);
    num  = {1'b0, mag} + {17'b0, src.d[DW-1:1]};
    work_d[2].rem  = num;
    work_d[2].q    = '0;
    work_d[2].dz   = (src.d == '0);
    // quotient would not fit in QW bits
    work_d[2].over = ({1'b0, num[RW-1:QW]} >= src.d);

    // restoring division, one quotient bit per stage, MSB first
    for (int j = 0; j < QW; j++) begin
      src = work_q[2+j];
      work_d[3+j] = src;
      dsh = {{(RW-DW){1'b0}}, src.d} << (QW - 1 - j);
      if (!src.over && (src.rem >= dsh)) begin
        work_d[3+j].rem          = src.rem - dsh;
        work_d[3+j].q[QW-1-j]    = 1'b1;
      end
    end

    // update with saturation
    src    = work_q[NumWork-1];
    item_d = src.item;
    qv     = src.over ? '1 : src.q;
    sum    = {2'b0, src.item.x} + {1'b0, qv};
    if (src.dz) begin
      item_d.err = 1'b1;
    end else if (src.fneg) begin
      if (sum[XW+1:XW] != 2'b00) begin
        item_d.x   = XMax;
        item_d.err = 1'b1;
      end else begin
        item_d.x = sum[XW-1:0];
      end
    end else if (qv > {1'b0, src.item.x}) begin
      item_d.x   = '0;
      item_d.err = 1'b1;
    end else begin
      item_d.x = src.item.x - qv[XW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      item_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q      <= {vld_q[NumWork-2:0], valid_i};
      item_vld_q <= vld_q[NumWork-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
      item_q <= item_d;
    end
  end

  assign valid_o = item_vld_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ----- hdl/newton_quadratic_current_solver.sv -----
// Top level of the Newton-Raphson LED current solver: clamp register and a
// chain of nqcs_step pipelines. Uses nqcs_pkg and nqcs_step.
//
// Usage:
//  - in channel (in_valid_i/in_ready_o/in_data_i): intensity (Q8.8) and the
//    coefficients a, b (Q4.12) of a*x*x + b*x = intensity.
//  - out channel (out_valid_o/out_ready_i/out_data_o): drive current x in
//    Q8.8 after ten Newton steps from zero, plus an error flag for a zero
//    derivative or a saturated step.
//  - cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i): max_intensity clamp,
//    always ready; write it only while the pipeline is empty.
//  - Each Newton step is a pipeline of two multiply stages (the second also
//    forms f'), one stage for f, 17 quotient-bit stages and one update stage.
//  - Throughput: one beat per cycle unless stalled; all stages move as one.
//  - A stalled output freezes every stage; in_ready_o falls in the same
//    cycle, so nothing is lost or repeated.
//  - Reset clears all valid bits and sets the clamp to 0xFFFF.
`default_nettype none

module newton_quadratic_current_solver (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire nqcs_pkg::nqcs_in_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output nqcs_pkg::nqcs_out_t     out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        cfg_data_i
);
  import nqcs_pkg::*;

  logic [15:0]              max_int_q;
  logic                     en;
  logic [NewtonSteps:0]     chain_vld;
  nqcs_item_t               chain_item [NewtonSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_int_q <= '1;
    end else if (cfg_valid_i) begin
      max_int_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;

  assign chain_vld[0]      = in_valid_i;
  assign chain_item[0].x   = '0;
  assign chain_item[0].a   = in_data_i.coef_a;
  assign chain_item[0].b   = in_data_i.coef_b;
  assign chain_item[0].c   = (in_data_i.intensity > max_int_q) ? max_int_q
                                                               : in_data_i.intensity;
  assign chain_item[0].err = 1'b0;

  for (genvar s = 0; s < NewtonSteps; s++) begin : g_step
    nqcs_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_vld[s]),
      .item_i  (chain_item[s]),
      .valid_o (chain_vld[s+1]),
      .item_o  (chain_item[s+1])
    );
  end

  assign out_valid_o              = chain_vld[NewtonSteps];
  assign out_data_o.drive_current = chain_item[NewtonSteps].x;
  assign out_data_o.solve_error   = chain_item[NewtonSteps].err;

endmodule

`default_nettype wire

// ----- verif/tb_newton_quadratic_current_solver.sv -----
// Testbench for newton_quadratic_current_solver: random and directed beats, a
// built-in Newton solver predictor and an in-order scoreboard.
// Depends on nqcs_pkg and the solver RTL.
`default_nettype none

module tb_newton_quadratic_current_solver;
  import nqcs_pkg::*;

  localparam int unsigned DrainCycles = 260;
  localparam int unsigned StallLimit  = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  nqcs_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  nqcs_out_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  newton_quadratic_current_solver u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  nqcs_in_t    pending_beats[$];
  nqcs_out_t   expected_currents[$];
  logic [15:0] clamp_max = 16'hFFFF;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          timed_out = 1'b0;
  bit          stim_done = 1'b0;

  function automatic nqcs_out_t solve_current(nqcs_in_t beat, logic [15:0] cmax);
    longint unsigned a, b, c, ux, pos, neg, d, mag, q;
    longint x;
    nqcs_out_t res;
    a = 64'(beat.coef_a);
    b = 64'(beat.coef_b);
    c = 64'((beat.intensity > cmax) ? cmax : beat.intensity);
    x = 0;
    res.solve_error = 1'b0;
    for (int i = 0; i < NewtonSteps; i++) begin
      ux = x;
      pos = a * ux * ux + ((b * ux) << 8);
      neg = c << 20;
      d = 2 * a * ux + (b << 8);
      if (d == 0) begin
        res.solve_error = 1'b1;
        continue;
      end
      mag = (pos >= neg) ? pos - neg : neg - pos;
      q = (mag + d / 2) / d;
      x = (pos >= neg) ? x - longint'(q) : x + longint'(q);
      if (x < 0) begin
        res.solve_error = 1'b1;
        x = 0;
      end else if (x > 65535) begin
        res.solve_error = 1'b1;
        x = 65535;
      end
    end
    res.drive_current = x[15:0];
    return res;
  endfunction

  // driver: per-beat random gap, payload held until accepted
  int unsigned send_gap = 0;
  int unsigned send_draw = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_currents.push_back(solve_current(in_data_i, clamp_max));
      send_draw = $urandom_range(0, 11);
      if (send_draw == 0 && pending_beats.size() != 0) begin
        in_data_i <= pending_beats.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        send_gap <= (send_draw == 0) ? 0 : send_draw - 1;
      end
    end else if (!in_valid_i && rst_ni) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_beats.size() != 0) begin
        in_data_i <= pending_beats.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // monitor with per-beat random stall
  int unsigned recv_gap = 0;
  int unsigned recv_draw = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_currents.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %h", out_data_o);
      end else begin
        nqcs_out_t exp_res;
        exp_res = expected_currents.pop_front();
        if (exp_res.drive_current !== out_data_o.drive_current ||
            exp_res.solve_error !== out_data_o.solve_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp current %h err %b, got current %h err %b",
                     exp_res.drive_current, exp_res.solve_error,
                     out_data_o.drive_current, out_data_o.solve_error);
        end
      end
      recv_draw = $urandom_range(0, 11);
      if (recv_draw != 0) begin
        out_ready_i <= 1'b0;
        recv_gap <= recv_draw - 1;
      end
    end else if (rst_ni && !out_ready_i) begin
      if (recv_gap != 0) recv_gap <= recv_gap - 1;
      else out_ready_i <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else if (rst_ni && !stim_done) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_newton_quadratic_current_solver: FAIL");
      $finish;
    end
  end

  // sampled at the falling edge so driver updates have settled
  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid_i || expected_currents.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_clamp(logic [15:0] value);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    clamp_max = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic nqcs_in_t rand_beat();
    nqcs_in_t beat;
    beat.intensity = 16'($urandom);
    case ($urandom_range(0, 3))
      0: beat.coef_a = 16'h0;
      1: beat.coef_a = 16'($urandom_range(0, 16'h1FFF));
      default: beat.coef_a = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: beat.coef_b = 16'h0;
      1: beat.coef_b = 16'($urandom_range(1, 16'h00FF));
      default: beat.coef_b = 16'($urandom);
    endcase
    if ($urandom_range(0, 7) == 0) beat.intensity = 16'($urandom_range(0, 16'h00FF));
    return beat;
  endfunction

  task automatic push_directed();
    logic [15:0] vals[4] = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
    // zero derivative at x=0 (a=b=0), extremes of all fields
    foreach (vals[i]) pending_beats.push_back(nqcs_in_t'{vals[i], 16'h0, 16'h0});
    foreach (vals[i]) begin
      pending_beats.push_back(nqcs_in_t'{16'hFFFF, vals[i], 16'hFFFF - vals[i]});
      pending_beats.push_back(nqcs_in_t'{vals[i], 16'h0000, vals[i] | 16'h0001});
      pending_beats.push_back(nqcs_in_t'{vals[i], vals[i], 16'h0000});
    end
    pending_beats.push_back(nqcs_in_t'{16'hFFFF, 16'h0001, 16'h0001}); // saturates high
    pending_beats.push_back(nqcs_in_t'{16'h0100, 16'h1000, 16'h1000});
  endtask

  initial begin
    logic [15:0] clamps[5] = '{16'h0000, 16'h0100, 16'h8000, 16'h1234, 16'hFFFF};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    push_directed();
    wait_drained();
    foreach (clamps[p]) begin
      write_clamp(p == 0 ? 16'hFFFF : clamps[p]);
      if (p == 0) write_clamp(clamps[0]);
      if (p == 0 || p == 4) push_directed();
      repeat (310) pending_beats.push_back(rand_beat());
      wait_drained();
    end
    // short final burst
    for (int i = 0; i < 40; i++) pending_beats.push_back(rand_beat());
    wait_drained();
    stim_done = 1'b1;
    if (mismatches == 0 && expected_currents.size() == 0)
      $display("tb_newton_quadratic_current_solver: PASS");
    else
      $display("tb_newton_quadratic_current_solver: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
